@@ rtl/vmns_pkg.sv @@
// Types, codes and fixed constants shared by the voxel map subtract block.
// No dependencies.
`default_nettype none
package vmns_pkg;

   localparam int COORD_W = 32;
   localparam int KEY_W   = 24;
   localparam int INV_W   = 24;
   localparam int LEAF_W  = 19;
   localparam int RAD_W   = 2;
   localparam int CSR_W   = 24;
   localparam int CIDX_W  = 2;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_QUERY    = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;
   localparam logic [1:0] STATUS_CLEARED  = 2'd3;

   localparam logic [CIDX_W-1:0] CSR_INV_LEAF    = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_LEAF_LENGTH = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_RADIUS      = 2'd2;

   localparam logic [INV_W-1:0]  INV_LEAF_RST    = 24'd327680;
   localparam logic [LEAF_W-1:0] LEAF_LENGTH_RST = 19'd13107;
   localparam logic [RAD_W-1:0]  RADIUS_RST      = 2'd2;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic signed [COORD_W-1:0]  z_coord;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       foreground;
      logic signed [KEY_W-1:0]    key_x;
      logic signed [KEY_W-1:0]    key_y;
      logic signed [KEY_W-1:0]    key_z;
      logic signed [COORD_W-1:0]  centre_x;
      logic signed [COORD_W-1:0]  centre_y;
      logic signed [COORD_W-1:0]  centre_z;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_CENTRE,
      ST_INS_RD,
      ST_INS_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       key_en;
      logic       cen_en;
      logic [1:0] axis;
      logic       ins_rd;
      logic       ins_wr;
      logic       scan_rd;
      logic       scan_chk;
      logic       clr_wr;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       nonempty;
      logic       grid_ok;
      logic       clr_last;
      logic       scan_last;
      logic       hit_any;
      logic       rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/vmns_ctrl.sv @@
// Sequencer for the voxel map subtract block.
// Depends on vmns_pkg; drives the datapath through cmd_type, reads sts_type.
`default_nettype none
module vmns_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_kind,
   output logic                   req_stall,
   input  wire vmns_pkg::sts_type sts,
   output vmns_pkg::cmd_type      cmd
);

   vmns_pkg::state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vmns_pkg::ST_CLEAR;
         axis_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_stall = 1'b1;
      case (state_ff)
         vmns_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = (sts.kind == vmns_pkg::KIND_CLEAR) ? vmns_pkg::ST_DONE
                                                              : vmns_pkg::ST_IDLE;
            end
         end
         vmns_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            axis_in   = 2'd0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_kind == vmns_pkg::KIND_CLEAR) begin
                  state_in = vmns_pkg::ST_CLEAR;
               end else if (req_kind == vmns_pkg::KIND_INSERT ||
                            req_kind == vmns_pkg::KIND_QUERY) begin
                  state_in = vmns_pkg::ST_KEY;
               end
            end
         end
         vmns_pkg::ST_KEY: begin
            cmd.key_en = 1'b1;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = vmns_pkg::ST_CENTRE;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         vmns_pkg::ST_CENTRE: begin
            cmd.cen_en = 1'b1;
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               if (sts.kind == vmns_pkg::KIND_INSERT) begin
                  state_in = vmns_pkg::ST_INS_RD;
               end else if (sts.nonempty) begin
                  state_in = vmns_pkg::ST_SCAN_RD;
               end else begin
                  state_in = vmns_pkg::ST_DONE;
               end
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         vmns_pkg::ST_INS_RD: begin
            if (sts.grid_ok) begin
               cmd.ins_rd = 1'b1;
               state_in   = vmns_pkg::ST_INS_WR;
            end else begin
               state_in = vmns_pkg::ST_DONE;
            end
         end
         vmns_pkg::ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            state_in   = vmns_pkg::ST_DONE;
         end
         vmns_pkg::ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = vmns_pkg::ST_SCAN_CHK;
         end
         vmns_pkg::ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            state_in = (sts.hit_any || sts.scan_last) ? vmns_pkg::ST_DONE
                                                      : vmns_pkg::ST_SCAN_RD;
         end
         vmns_pkg::ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = vmns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vmns_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/vmns_dp.sv @@
// Datapath: item and key registers, multipliers, occupancy row memory,
// neighbourhood scan, settings registers and result register.
// Depends on vmns_pkg; sequenced by vmns_ctrl.
`default_nettype none
module vmns_dp #(
   parameter int KEY_BITS_XY = 7,
   parameter int KEY_BITS_Z  = 5,
   parameter int MAX_RADIUS  = 3
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire vmns_pkg::req_type              req_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [vmns_pkg::CIDX_W-1:0]    csr_index,
   input  wire logic [vmns_pkg::CSR_W-1:0]     csr_wdata,
   input  wire vmns_pkg::cmd_type              cmd,
   output vmns_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output vmns_pkg::rsp_type                   rsp_data
);

   localparam int ROW_AW = 2 * KEY_BITS_XY + KEY_BITS_Z - KEY_BITS_XY;
   localparam int ROWS   = 1 << ROW_AW;
   localparam int ROW_W  = 1 << KEY_BITS_XY;
   localparam int RW     = $clog2(2 * MAX_RADIUS + 1) + 1;
   localparam int NB     = vmns_pkg::KEY_W + 1;
   localparam int SPAN   = 2 * MAX_RADIUS + 1;
   localparam logic signed [NB-1:0] HALF_XY = NB'(1) << (KEY_BITS_XY - 1);
   localparam logic signed [NB-1:0] HALF_Z  = NB'(1) << (KEY_BITS_Z - 1);
   localparam logic [RW-1:0] MAX_R = RW'(MAX_RADIUS);

   // settings
   logic [vmns_pkg::INV_W-1:0]  inv_leaf_ff;
   logic [vmns_pkg::LEAF_W-1:0] leaf_length_ff;
   logic [vmns_pkg::RAD_W-1:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_leaf_ff    <= vmns_pkg::INV_LEAF_RST;
         leaf_length_ff <= vmns_pkg::LEAF_LENGTH_RST;
         radius_ff      <= vmns_pkg::RADIUS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            vmns_pkg::CSR_INV_LEAF:    inv_leaf_ff    <= csr_wdata[vmns_pkg::INV_W-1:0];
            vmns_pkg::CSR_LEAF_LENGTH: leaf_length_ff <= csr_wdata[vmns_pkg::LEAF_W-1:0];
            vmns_pkg::CSR_RADIUS:      radius_ff      <= csr_wdata[vmns_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   logic [RW-1:0] r_eff, two_r;
   assign r_eff = ({{(RW-vmns_pkg::RAD_W){1'b0}}, radius_ff} > MAX_R)
                  ? MAX_R : {{(RW-vmns_pkg::RAD_W){1'b0}}, radius_ff};
   assign two_r = r_eff << 1;

   // item registers
   logic [1:0]                          kind_ff;
   logic signed [vmns_pkg::COORD_W-1:0] coord_ff  [3];
   logic signed [vmns_pkg::KEY_W-1:0]   key_ff    [3];
   logic signed [vmns_pkg::COORD_W-1:0] centre_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= vmns_pkg::KIND_INSERT;
      end else if (cmd.accept) begin
         kind_ff <= req_data.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         coord_ff[0] <= req_data.x_coord;
         coord_ff[1] <= req_data.y_coord;
         coord_ff[2] <= req_data.z_coord;
      end
   end

   // key = floor(coord * inv_leaf / 2^32), one axis a cycle
   logic signed [56:0] key_prod;
   assign key_prod = coord_ff[cmd.axis] * $signed({1'b0, inv_leaf_ff});

   // centre = floor((2k+1) * leaf / 2), saturated
   logic signed [44:0] cen_prod;
   logic signed [43:0] cen_half;
   logic signed [vmns_pkg::COORD_W-1:0] cen_sat;
   assign cen_prod = $signed({key_ff[cmd.axis], 1'b1}) * $signed({1'b0, leaf_length_ff});
   assign cen_half = cen_prod[44:1];
   always_comb begin
      if ((&cen_half[43:31]) || !(|cen_half[43:31])) begin
         cen_sat = cen_half[31:0];
      end else if (cen_half[43]) begin
         cen_sat = 32'sh8000_0000;
      end else begin
         cen_sat = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_en) begin
         key_ff[cmd.axis] <= key_prod[55:32];
      end
      if (cmd.cen_en) begin
         centre_ff[cmd.axis] <= cen_sat;
      end
   end

   // grid check and row addressing of the item's own voxel
   logic signed [NB-1:0] kx, ky, kz;
   assign kx = NB'(key_ff[0]);
   assign ky = NB'(key_ff[1]);
   assign kz = NB'(key_ff[2]);

   logic grid_ok;
   assign grid_ok = (kx >= -HALF_XY) && (kx < HALF_XY) &&
                    (ky >= -HALF_XY) && (ky < HALF_XY) &&
                    (kz >= -HALF_Z)  && (kz < HALF_Z);

   logic [ROW_AW-1:0]      ins_addr;
   logic [KEY_BITS_XY-1:0] ins_bit;
   assign ins_addr = {~kz[KEY_BITS_Z-1], kz[KEY_BITS_Z-2:0],
                      ~ky[KEY_BITS_XY-1], ky[KEY_BITS_XY-2:0]};
   assign ins_bit  = {~kx[KEY_BITS_XY-1], kx[KEY_BITS_XY-2:0]};

   // neighbourhood scan: one row (fixed dy, dz) per read
   logic [RW-1:0] uy_ff, uz_ff;
   logic          hit_ff;
   logic          row_ok_ff;
   logic signed [NB-1:0] ny, nz;
   logic                 row_ok;
   logic [ROW_AW-1:0]    scan_addr;
   logic                 scan_last;

   assign ny = ky + $signed(NB'(uy_ff)) - $signed(NB'(r_eff));
   assign nz = kz + $signed(NB'(uz_ff)) - $signed(NB'(r_eff));
   assign row_ok = (ny >= -HALF_XY) && (ny < HALF_XY) && (nz >= -HALF_Z) && (nz < HALF_Z);
   assign scan_addr = {~nz[KEY_BITS_Z-1], nz[KEY_BITS_Z-2:0],
                       ~ny[KEY_BITS_XY-1], ny[KEY_BITS_XY-2:0]};
   assign scan_last = (uy_ff == two_r) && (uz_ff == two_r);

   // occupancy memory, one row of x per word
   logic [ROW_W-1:0]  occ_mem [ROWS];
   logic [ROW_W-1:0]  rdata_ff;
   logic [ROW_AW-1:0] clr_cnt_ff;
   logic              nonempty_ff;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         occ_mem[clr_cnt_ff] <= '0;
      end else if (cmd.ins_wr) begin
         occ_mem[ins_addr] <= rdata_ff | (ROW_W'(1) << ins_bit);
      end
      if (cmd.scan_rd) begin
         rdata_ff <= occ_mem[scan_addr];
      end else if (cmd.ins_rd) begin
         rdata_ff <= occ_mem[ins_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         row_ok_ff <= row_ok;
      end
   end

   // x taps of the current row
   logic hit_now;
   always_comb begin
      logic signed [NB-1:0] nx;
      hit_now = 1'b0;
      for (int i = 0; i < SPAN; i++) begin
         nx = kx + NB'(i) - NB'(MAX_RADIUS);
         if (i >= MAX_RADIUS - int'(r_eff) && i <= MAX_RADIUS + int'(r_eff) &&
             nx >= -HALF_XY && nx < HALF_XY && row_ok_ff &&
             rdata_ff[{~nx[KEY_BITS_XY-1], nx[KEY_BITS_XY-2:0]}]) begin
            hit_now = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         nonempty_ff <= 1'b0;
         uy_ff       <= '0;
         uz_ff       <= '0;
         hit_ff      <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_cnt_ff  <= clr_cnt_ff + 1'b1;
            nonempty_ff <= 1'b0;
         end else if (cmd.ins_wr) begin
            nonempty_ff <= 1'b1;
         end
         if (cmd.accept) begin
            uy_ff  <= '0;
            uz_ff  <= '0;
            hit_ff <= 1'b0;
         end else if (cmd.scan_chk) begin
            hit_ff <= hit_ff | hit_now;
            if (uy_ff == two_r) begin
               uy_ff <= '0;
               uz_ff <= uz_ff + 1'b1;
            end else begin
               uy_ff <= uy_ff + 1'b1;
            end
         end
      end
   end

   // result register
   logic              rsp_valid_ff;
   vmns_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in          = '0;
      rsp_in.key_x    = key_ff[0];
      rsp_in.key_y    = key_ff[1];
      rsp_in.key_z    = key_ff[2];
      rsp_in.centre_x = centre_ff[0];
      rsp_in.centre_y = centre_ff[1];
      rsp_in.centre_z = centre_ff[2];
      case (kind_ff)
         vmns_pkg::KIND_INSERT: begin
            rsp_in.status = grid_ok ? vmns_pkg::STATUS_INSERTED : vmns_pkg::STATUS_OUTSIDE;
         end
         vmns_pkg::KIND_QUERY: begin
            rsp_in.status     = vmns_pkg::STATUS_QUERY;
            rsp_in.foreground = ~hit_ff;
         end
         default: begin
            rsp_in = '0;
            rsp_in.status = vmns_pkg::STATUS_CLEARED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.kind      = kind_ff;
   assign sts.nonempty  = nonempty_ff;
   assign sts.grid_ok   = grid_ok;
   assign sts.clr_last  = &clr_cnt_ff;
   assign sts.scan_last = scan_last;
   assign sts.hit_any   = hit_ff | hit_now;
   assign sts.rsp_busy  = rsp_valid_ff & rsp_stall;

endmodule
`default_nettype wire

@@ rtl/voxel_map_neighbourhood_subtract.sv @@
// Top level of the voxel occupancy map with neighbourhood background subtraction.
// Depends on vmns_pkg, vmns_ctrl and vmns_dp.
//
//   port group | direction | word          | handshake
//   req_*      | in        | req_type      | req_valid / req_stall
//   rsp_*      | out       | rsp_type      | rsp_valid / rsp_stall
//   csr_*      | in        | 24-bit data   | csr_wr_en, no wait
//
// One word at a time. Insert works out key and centre axis by axis, then reads
// and writes its row (no row access when the key is outside the grid); a query
// works them out too, then reads and checks one row after another (up to (2r+1)^2
// rows, fewer on an early hit or empty map) in the single-port occupancy row memory.
// An unused kind is taken and dropped. A clear word sweeps all 2^(KEY_BITS_XY+KEY_BITS_Z)
// rows (4096 at defaults) one row a cycle, then returns a cleared word.
// Reset is synchronous; the same sweep runs after reset with req_stall high.
// A finished word waits in the result register while rsp_stall is high; the
// next word is taken meanwhile and parks until the register frees.
`default_nettype none
module voxel_map_neighbourhood_subtract #(
   parameter int KEY_BITS_XY = 7,
   parameter int KEY_BITS_Z  = 5,
   parameter int MAX_RADIUS  = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire vmns_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output vmns_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [vmns_pkg::CIDX_W-1:0] csr_index,
   input  wire logic [vmns_pkg::CSR_W-1:0]  csr_wdata
);

   vmns_pkg::cmd_type cmd;
   vmns_pkg::sts_type sts;

   vmns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vmns_dp #(
      .KEY_BITS_XY (KEY_BITS_XY),
      .KEY_BITS_Z  (KEY_BITS_Z),
      .MAX_RADIUS  (MAX_RADIUS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // foreground is only ever reported by a query
   a_fg_query_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != vmns_pkg::STATUS_QUERY |-> !rsp_data.foreground)
      else $error("foreground set on a non-query word");

   // a cleared word carries zero key and centre (checked on key_x and centre_z)
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == vmns_pkg::STATUS_CLEARED |->
         rsp_data.key_x == '0 && rsp_data.centre_z == '0)
      else $error("clear word with nonzero key or centre");

   // an accepted word of a known kind keeps the input side busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.kind == vmns_pkg::KIND_INSERT || req_data.kind == vmns_pkg::KIND_QUERY ||
       req_data.kind == vmns_pkg::KIND_CLEAR) |=> req_stall)
      else $error("input taken while a word is in flight");

endmodule
`default_nettype wire
